// File: design/elg_pkg.sv
// Shared types and constants for the masked ElGamal encryption block.
`default_nettype none

package elg_pkg;

    // Configuration register indexes
    typedef logic [1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_MODULUS    = 2'd0;
    localparam t_cfg_idx CFG_SENDER_PUB = 2'd1;
    localparam t_cfg_idx CFG_SECRET_EXP = 2'd2;

    // Register values after reset
    localparam int unsigned RST_MODULUS    = 59;
    localparam int unsigned RST_SENDER_PUB = 16;
    localparam int unsigned RST_SECRET_EXP = 5;

    // Mask sequencer states
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_BASE = 5'b00100,
        S_MUL  = 5'b01000,
        S_SQR  = 5'b10000
    } t_seq_state;

endpackage

`default_nettype wire

// File: design/elg_mm_step.sv
// One step of interleaved modular multiplication: (2*acc + bit*y) mod p.
`default_nettype none

module elg_mm_step
    import elg_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic [VALUE_WIDTH-1:0] i_acc,
    input  wire logic                   i_bit,
    input  wire logic [VALUE_WIDTH-1:0] i_y,
    input  wire logic [VALUE_WIDTH-1:0] i_modulus,
    output logic      [VALUE_WIDTH-1:0] o_res
);

    logic [VALUE_WIDTH:0] w_pe;
    logic [VALUE_WIDTH:0] w_dbl;
    logic [VALUE_WIDTH:0] w_red;
    logic [VALUE_WIDTH:0] w_sum;
    logic [VALUE_WIDTH:0] w_fin;

    // Double and fold back below p
    assign w_pe  = {1'b0, i_modulus};
    assign w_dbl = {i_acc, 1'b0};
    assign w_red = (w_dbl >= w_pe) ? (w_dbl - w_pe) : w_dbl;

    // Add the multiplicand when the bit is set and fold again
    assign w_sum = w_red + (i_bit ? {1'b0, i_y} : {(VALUE_WIDTH+1){1'b0}});
    assign w_fin = (w_sum >= w_pe) ? (w_sum - w_pe) : w_sum;

    assign o_res = w_fin[VALUE_WIDTH-1:0];

endmodule

`default_nettype wire

// File: design/elg_mm_cell.sv
// Pipeline cell: handles one message bit of the mask * message product.
`default_nettype none

module elg_mm_cell
    import elg_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire logic [VALUE_WIDTH-1:0] i_acc,
    input  wire logic [VALUE_WIDTH-1:0] i_msg,
    input  wire logic [VALUE_WIDTH-1:0] i_mask,
    input  wire logic [VALUE_WIDTH-1:0] i_modulus,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic      [VALUE_WIDTH-1:0] o_acc,
    output logic      [VALUE_WIDTH-1:0] o_msg
);

    logic                   r_valid;
    logic [VALUE_WIDTH-1:0] r_acc;
    logic [VALUE_WIDTH-1:0] r_msg;
    logic                   w_adv;
    logic [VALUE_WIDTH-1:0] w_res;

    // Take a word when the slot is empty or drains this cycle
    assign w_adv   = !r_valid || i_ready;
    assign o_ready = w_adv;

    elg_mm_step #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_step (
        .i_acc     (i_acc),
        .i_bit     (i_msg[VALUE_WIDTH-1]),
        .i_y       (i_mask),
        .i_modulus (i_modulus),
        .o_res     (w_res)
    );

    // Track occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_adv) begin
            r_valid <= i_valid;
        end
    end

    // Advance partial product and shift the next bit to the top
    always_ff @(posedge i_clk) begin
        if (w_adv && i_valid) begin
            r_acc <= w_res;
            r_msg <= {i_msg[VALUE_WIDTH-2:0], 1'b0};
        end
    end

    assign o_valid = r_valid;
    assign o_acc   = r_acc;
    assign o_msg   = r_msg;

endmodule

`default_nettype wire

// File: design/elg_mask_seq.sv
// Sequencer that computes the mask base^expo mod p by square-and-multiply.
`default_nettype none

module elg_mask_seq
    import elg_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_start,
    input  wire logic [VALUE_WIDTH-1:0] i_modulus,
    input  wire logic [VALUE_WIDTH-1:0] i_base,
    input  wire logic [VALUE_WIDTH-1:0] i_expo,
    output logic      [VALUE_WIDTH-1:0] o_mask,
    output logic                        o_busy
);

    localparam int CW = $clog2(VALUE_WIDTH);
    localparam logic [CW-1:0] LAST = CW'(VALUE_WIDTH - 1);

    t_seq_state             r_state, n_state;
    logic [CW-1:0]          r_cnt, n_cnt;
    logic [CW-1:0]          r_ecnt, n_ecnt;
    logic [VALUE_WIDTH-1:0] r_part, n_part;
    logic [VALUE_WIDTH-1:0] r_x, n_x;
    logic [VALUE_WIDTH-1:0] r_y, n_y;
    logic [VALUE_WIDTH-1:0] r_acc, n_acc;
    logic [VALUE_WIDTH-1:0] r_b, n_b;
    logic [VALUE_WIDTH-1:0] r_exp, n_exp;
    logic [VALUE_WIDTH-1:0] w_one;
    logic [VALUE_WIDTH-1:0] w_res;
    logic                   w_last;
    logic                   w_work;

    // One reduced mod p: zero when p is one
    assign w_one  = {{(VALUE_WIDTH-1){1'b0}}, (i_modulus != VALUE_WIDTH'(1))};
    assign w_last = (r_cnt == LAST);
    assign w_work = (r_state == S_BASE) || (r_state == S_MUL) || (r_state == S_SQR);

    elg_mm_step #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_step (
        .i_acc     (r_part),
        .i_bit     (r_x[VALUE_WIDTH-1]),
        .i_y       (r_y),
        .i_modulus (i_modulus),
        .o_res     (w_res)
    );

    // Step through one multiplier bit a cycle; chain multiplies per exponent bit
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_ecnt  = r_ecnt;
        n_part  = r_part;
        n_x     = r_x;
        n_y     = r_y;
        n_acc   = r_acc;
        n_b     = r_b;
        n_exp   = r_exp;
        case (r_state)
            S_IDLE: begin
            end
            S_LOAD: begin
                n_state = S_BASE;
                n_part  = '0;
                n_x     = i_base;
                n_y     = w_one;
                n_cnt   = '0;
                n_acc   = w_one;
                n_exp   = i_expo;
                n_ecnt  = '0;
            end
            S_BASE: begin
                n_part = w_res;
                n_x    = {r_x[VALUE_WIDTH-2:0], 1'b0};
                n_cnt  = r_cnt + 1'b1;
                if (w_last) begin
                    // Base reduced; start on the lowest exponent bit
                    n_b    = w_res;
                    n_part = '0;
                    n_cnt  = '0;
                    if (r_exp[0]) begin
                        n_state = S_MUL;
                        n_x     = r_acc;
                        n_y     = w_res;
                    end else begin
                        n_state = S_SQR;
                        n_x     = w_res;
                        n_y     = w_res;
                    end
                end
            end
            S_MUL: begin
                n_part = w_res;
                n_x    = {r_x[VALUE_WIDTH-2:0], 1'b0};
                n_cnt  = r_cnt + 1'b1;
                if (w_last) begin
                    n_acc   = w_res;
                    n_state = S_SQR;
                    n_part  = '0;
                    n_cnt   = '0;
                    n_x     = r_b;
                    n_y     = r_b;
                end
            end
            S_SQR: begin
                n_part = w_res;
                n_x    = {r_x[VALUE_WIDTH-2:0], 1'b0};
                n_cnt  = r_cnt + 1'b1;
                if (w_last) begin
                    n_b    = w_res;
                    n_exp  = {1'b0, r_exp[VALUE_WIDTH-1:1]};
                    n_ecnt = r_ecnt + 1'b1;
                    n_part = '0;
                    n_cnt  = '0;
                    if (r_ecnt == LAST) begin
                        n_state = S_IDLE;
                    end else if (r_exp[1]) begin
                        n_state = S_MUL;
                        n_x     = r_acc;
                        n_y     = w_res;
                    end else begin
                        n_state = S_SQR;
                        n_x     = w_res;
                        n_y     = w_res;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Restart on reset or any register write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
        end else if (i_start) begin
            r_state <= S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // Datapath and counters
    always_ff @(posedge i_clk) begin
        r_cnt  <= n_cnt;
        r_ecnt <= n_ecnt;
        r_part <= n_part;
        r_x    <= n_x;
        r_y    <= n_y;
        r_acc  <= n_acc;
        r_b    <= n_b;
        r_exp  <= n_exp;
    end

    assign o_mask = r_acc;
    assign o_busy = (r_state != S_IDLE);

    // Partial product stays reduced while the multiplier runs
    a_part_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_work && (i_modulus != '0)) |-> (r_part < i_modulus))
        else $error("partial product not reduced below modulus");

    // Operands of the exponent loop stay reduced
    a_ops_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (((r_state == S_MUL) || (r_state == S_SQR)) && (i_modulus != '0))
        |-> ((r_acc < i_modulus) && (r_b < i_modulus)))
        else $error("mask operands not reduced below modulus");

endmodule

`default_nettype wire

// File: design/elgamal_mask_encrypt.sv
// An accepted message word passes through the row of VALUE_WIDTH multiplier cells, then the output register.
// Throughput: one message per cycle while no mask update runs and the output is not stalled.
// Mask update: after reset and after each register write the mask sequencer recomputes
// the mask by square-and-multiply; no message is taken while it runs.
// Reset: synchronous active-low; registers return to modulus 59, key 16, exponent 5,
// the pipeline empties and the mask is recomputed.
`default_nettype none

module elgamal_mask_encrypt
    import elg_pkg::*;
#(
    parameter int VALUE_WIDTH = 16
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    // configuration writes
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire t_cfg_idx               i_cfg_index,
    input  wire logic [VALUE_WIDTH-1:0] i_cfg_data,
    // message words
    input  wire logic                   i_msg_valid,
    output logic                        o_msg_ready,
    input  wire logic [VALUE_WIDTH-1:0] i_message,
    // ciphertext words
    output logic                        o_ct_valid,
    input  wire logic                   i_ct_ready,
    output logic      [VALUE_WIDTH-1:0] o_ciphertext
);

    logic [VALUE_WIDTH-1:0] r_modulus;
    logic [VALUE_WIDTH-1:0] r_sender_pub;
    logic [VALUE_WIDTH-1:0] r_secret_exp;
    logic                   r_ct_valid;
    logic [VALUE_WIDTH-1:0] r_ct;

    logic [VALUE_WIDTH-1:0] w_mask;
    logic                   w_busy;
    logic                   w_cfg_wr;
    logic                   w_out_rdy;

    logic                   w_valid [VALUE_WIDTH+1];
    logic                   w_ready [VALUE_WIDTH+1];
    logic [VALUE_WIDTH-1:0] w_acc   [VALUE_WIDTH+1];
    logic [VALUE_WIDTH-1:0] w_msg   [VALUE_WIDTH+1];

    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus    <= VALUE_WIDTH'(RST_MODULUS);
            r_sender_pub <= VALUE_WIDTH'(RST_SENDER_PUB);
            r_secret_exp <= VALUE_WIDTH'(RST_SECRET_EXP);
        end else if (w_cfg_wr) begin
            case (i_cfg_index)
                CFG_MODULUS:    r_modulus    <= i_cfg_data;
                CFG_SENDER_PUB: r_sender_pub <= i_cfg_data;
                CFG_SECRET_EXP: r_secret_exp <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    elg_mask_seq #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) u_seq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_cfg_wr),
        .i_modulus (r_modulus),
        .i_base    (r_sender_pub),
        .i_expo    (r_secret_exp),
        .o_mask    (w_mask),
        .o_busy    (w_busy)
    );

    // Feed the first cell; hold off while the mask is being computed
    assign w_valid[0]  = i_msg_valid && !w_busy;
    assign w_acc[0]    = '0;
    assign w_msg[0]    = i_message;
    assign o_msg_ready = w_ready[0] && !w_busy;

    // Row of cells, most significant message bit first
    for (genvar k = 0; k < VALUE_WIDTH; k++) begin : g_cell
        elg_mm_cell #(
            .VALUE_WIDTH(VALUE_WIDTH)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (w_valid[k]),
            .o_ready   (w_ready[k]),
            .i_acc     (w_acc[k]),
            .i_msg     (w_msg[k]),
            .i_mask    (w_mask),
            .i_modulus (r_modulus),
            .o_valid   (w_valid[k+1]),
            .i_ready   (w_ready[k+1]),
            .o_acc     (w_acc[k+1]),
            .o_msg     (w_msg[k+1])
        );
    end

    // Output register parts the row from the downstream side
    assign w_out_rdy             = !r_ct_valid || i_ct_ready;
    assign w_ready[VALUE_WIDTH] = w_out_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ct_valid <= 1'b0;
        end else if (w_out_rdy) begin
            r_ct_valid <= w_valid[VALUE_WIDTH];
        end
    end

    // Drop to zero when there is no modulus to reduce by
    always_ff @(posedge i_clk) begin
        if (w_out_rdy && w_valid[VALUE_WIDTH]) begin
            r_ct <= (r_modulus == '0) ? '0 : w_acc[VALUE_WIDTH];
        end
    end

    assign o_ct_valid   = r_ct_valid;
    assign o_ciphertext = r_ct;

    // No message taken while the mask is stale
    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_msg_valid && o_msg_ready && w_busy))
        else $error("message accepted during mask update");

    // Every register write restarts the mask computation
    a_cfg_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> w_busy)
        else $error("register write did not restart mask update");

    // Reset starts a mask computation
    a_rst_restarts: assert property (@(posedge i_clk)
        !i_rst_n |=> w_busy)
        else $error("reset did not start mask update");

endmodule

`default_nettype wire
